// ----- rtl/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every clock edge out of reset.
`define TTAS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check on every clock edge, reset included.
`define TTAS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/ttas_pkg.sv -----
package ttas_pkg;

  localparam int SEQ_MAX       = 14;
  localparam int SEQ_POS_W     = $clog2(SEQ_MAX);
  localparam int FIFO_DEPTH_DF = 2;

  localparam logic [7:0] ATTR_FG_MASK = 8'h07;
  localparam logic [7:0] ATTR_BG_MASK = 8'h70;
  localparam logic [7:0] ATTR_DEFAULT = 8'h07;

  localparam logic [7:0] CHAR_ESC   = 8'h1B;
  localparam logic [7:0] CHAR_LBRK  = 8'h5B;
  localparam logic [7:0] CHAR_SEMI  = 8'h3B;
  localparam logic [7:0] CHAR_M     = 8'h6D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_ONE   = 8'h31;
  localparam logic [7:0] CHAR_THREE = 8'h33;
  localparam logic [7:0] CHAR_FOUR  = 8'h34;
  localparam logic [7:0] CHAR_FIVE  = 8'h35;

  // Byte positions within the longest sequence
  localparam logic [SEQ_POS_W-1:0] POS_ESC    = 4'd0;
  localparam logic [SEQ_POS_W-1:0] POS_LBRK   = 4'd1;
  localparam logic [SEQ_POS_W-1:0] POS_RST    = 4'd2;
  localparam logic [SEQ_POS_W-1:0] POS_RST_S  = 4'd3;
  localparam logic [SEQ_POS_W-1:0] POS_BLK    = 4'd4;
  localparam logic [SEQ_POS_W-1:0] POS_BLK_S  = 4'd5;
  localparam logic [SEQ_POS_W-1:0] POS_BLD    = 4'd6;
  localparam logic [SEQ_POS_W-1:0] POS_BLD_S  = 4'd7;
  localparam logic [SEQ_POS_W-1:0] POS_FG     = 4'd8;
  localparam logic [SEQ_POS_W-1:0] POS_FG_C   = 4'd9;
  localparam logic [SEQ_POS_W-1:0] POS_FG_S   = 4'd10;
  localparam logic [SEQ_POS_W-1:0] POS_BG     = 4'd11;
  localparam logic [SEQ_POS_W-1:0] POS_BG_C   = 4'd12;
  localparam logic [SEQ_POS_W-1:0] POS_BG_S   = 4'd13;

  typedef struct packed {
    logic [7:0] attr;
    logic [7:0] current_attr;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
  } out_t;

  typedef struct packed {
    logic       rst;
    logic       blk;
    logic       bld;
    logic       fgd;
    logic       bgd;
    logic [2:0] fg_code;
    logic [2:0] bg_code;
  } desc_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

  function automatic logic [2:0] pc_to_ansi(input logic [2:0] pc);
    return {pc[0], pc[1], pc[2]};
  endfunction

  function automatic logic [SEQ_MAX-1:0] seq_mask(input desc_t d);
    return {{3{d.bgd}}, {3{d.fgd}}, {2{d.bld}}, {2{d.blk}}, {2{d.rst}}, 2'b11};
  endfunction

endpackage

// ----- rtl/text_attribute_to_ansi_sgr.sv -----
// The first byte of a sequence follows its descriptor through the queue and the back
// end's descriptor register. Throughput: one output byte per cycle while out_ready is
// high; 0 (no change) to 14 bytes per sequence, set by the back end's byte sequencer.
// A descriptor queue of FIFO_DEPTH entries lets the front accept while bytes stream.
// Reset (rst_n low, synchronous): queue and sequencer empty, color_en_r set to 1.
`include "assert_macros.svh"

module text_attribute_to_ansi_sgr import ttas_pkg::*; #(
  parameter int FIFO_DEPTH = FIFO_DEPTH_DF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic cfg_we,
  input  logic cfg_wdata,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  fifo_status_t fifo_st;
  logic         push;
  logic         pop;
  desc_t        push_desc;
  desc_t        pop_desc;

  ttas_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .fifo_st   (fifo_st),
    .push      (push),
    .push_desc (push_desc)
  );

  ttas_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_desc (push_desc),
    .pop       (pop),
    .pop_desc  (pop_desc),
    .st        (fifo_st)
  );

  ttas_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .fifo_st   (fifo_st),
    .pop_desc  (pop_desc),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  `TTAS_ASSERT(a_no_overflow, push |-> !fifo_st.full, "descriptor pushed into full queue")
  `TTAS_ASSERT(a_no_underflow, pop |-> !fifo_st.empty, "descriptor popped from empty queue")
  `TTAS_ASSERT(a_last_is_m, out_valid && out_data.last |-> out_data.out_byte == CHAR_M, "last byte not m")
  `TTAS_ASSERT(a_esc_not_last, out_valid && out_data.out_byte == CHAR_ESC |-> !out_data.last, "ESC flagged last")
  `TTAS_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !out_valid, "output valid after reset")

endmodule

// ----- rtl/ttas_front.sv -----
module ttas_front import ttas_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic         cfg_wdata,
  input  logic         in_valid,
  output logic         in_ready,
  input  in_t          in_data,
  input  fifo_status_t fifo_st,
  output logic         push,
  output desc_t        push_desc
);

  logic       color_en_r;
  logic [7:0] want;
  logic [7:0] cur;
  logic [7:0] cur_eff;
  logic       fg_any;
  logic       bg_any;
  logic       same;
  logic       any_work;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      color_en_r <= 1'b1;
    end else if (cfg_we) begin
      color_en_r <= cfg_wdata;
    end
  end

  always_comb begin
    cur    = in_data.current_attr;
    want   = in_data.attr;
    fg_any = |(want & ATTR_FG_MASK);
    bg_any = |(want & ATTR_BG_MASK);
    if (!color_en_r) begin
      if (fg_any) begin
        want = want | ATTR_FG_MASK;
      end
      if (bg_any) begin
        want = want | ATTR_BG_MASK;
      end
      if (fg_any && bg_any) begin
        want = want & ~ATTR_FG_MASK;
      end
      if (want == 8'h00) begin
        want = ATTR_DEFAULT;
      end
    end
    same = (want == cur);

    push_desc.rst = (!want[3] && cur[3]) || (!want[7] && cur[7]) || (want == ATTR_DEFAULT);
    cur_eff       = push_desc.rst ? ATTR_DEFAULT : cur;
    push_desc.blk = want[7] && !cur_eff[7];
    push_desc.bld = want[3] && !cur_eff[3];
    push_desc.fgd = (want[2:0] != cur_eff[2:0]);
    push_desc.bgd = (want[6:4] != cur_eff[6:4]);
    push_desc.fg_code = pc_to_ansi(want[2:0]);
    push_desc.bg_code = pc_to_ansi(want[6:4]);
    any_work = push_desc.rst || push_desc.blk || push_desc.bld ||
               push_desc.fgd || push_desc.bgd;
  end

  assign in_ready = !fifo_st.full;
  assign push     = in_valid && in_ready && !same && any_work;

endmodule

// ----- rtl/ttas_fifo.sv -----
module ttas_fifo import ttas_pkg::*; #(
  parameter int DEPTH = FIFO_DEPTH_DF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  desc_t        push_desc,
  input  logic         pop,
  output desc_t        pop_desc,
  output fifo_status_t st
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  desc_t              mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_desc;
    end
  end

  assign pop_desc = mem_r[rd_ptr_r];
  assign st.full  = (cnt_r == CNT_W'(DEPTH));
  assign st.empty = (cnt_r == '0);

endmodule

// ----- rtl/ttas_back.sv -----
module ttas_back import ttas_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  fifo_status_t fifo_st,
  input  desc_t        pop_desc,
  output logic         pop,
  output logic         out_valid,
  input  logic         out_ready,
  output out_t         out_data
);

  logic                 act_r, act_nxt;
  desc_t                desc_r, desc_nxt;
  logic [SEQ_POS_W-1:0] pos_r, pos_nxt;
  logic                 out_valid_r, out_valid_nxt;
  out_t                 out_r, out_nxt;

  logic [SEQ_MAX-1:0]   mask;
  logic [SEQ_POS_W-1:0] next_pos;
  logic                 done;
  logic                 advance;
  logic [7:0]           tmpl_byte;

  always_comb begin
    mask     = seq_mask(desc_r);
    next_pos = pos_r;
    done     = 1'b1;
    for (int i = SEQ_MAX - 1; i >= 0; i--) begin
      if (mask[i] && (SEQ_POS_W'(i) > pos_r)) begin
        next_pos = SEQ_POS_W'(i);
        done     = 1'b0;
      end
    end
  end

  always_comb begin
    case (pos_r)
      POS_ESC:   tmpl_byte = CHAR_ESC;
      POS_LBRK:  tmpl_byte = CHAR_LBRK;
      POS_RST:   tmpl_byte = CHAR_ZERO;
      POS_BLK:   tmpl_byte = CHAR_FIVE;
      POS_BLD:   tmpl_byte = CHAR_ONE;
      POS_FG:    tmpl_byte = CHAR_THREE;
      POS_FG_C:  tmpl_byte = CHAR_ZERO | {5'd0, desc_r.fg_code};
      POS_BG:    tmpl_byte = CHAR_FOUR;
      POS_BG_C:  tmpl_byte = CHAR_ZERO | {5'd0, desc_r.bg_code};
      default:   tmpl_byte = CHAR_SEMI;
    endcase
  end

  assign advance = act_r && (!out_valid_r || out_ready);
  assign pop     = !fifo_st.empty && (!act_r || (advance && done));

  always_comb begin
    act_nxt       = act_r;
    desc_nxt      = desc_r;
    pos_nxt       = pos_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    if (advance) begin
      out_valid_nxt    = 1'b1;
      out_nxt.out_byte = done ? CHAR_M : tmpl_byte;
      out_nxt.last     = done;
      pos_nxt          = next_pos;
      if (done) begin
        act_nxt = 1'b0;
      end
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (pop) begin
      act_nxt  = 1'b1;
      desc_nxt = pop_desc;
      pos_nxt  = POS_ESC;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r       <= 1'b0;
      pos_r       <= POS_ESC;
      out_valid_r <= 1'b0;
    end else begin
      act_r       <= act_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    desc_r <= desc_nxt;
    out_r  <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ----- verif/tb_text_attribute_to_ansi_sgr.sv -----
`timescale 1ns / 1ps

module tb_text_attribute_to_ansi_sgr;
  import ttas_pkg::*;

  localparam int PHASES = 6;
  localparam int PHASE_ITEMS = 82;
  localparam logic [2:0] ANSI_HUE [8] = '{3'd0, 3'd4, 3'd2, 3'd6, 3'd1, 3'd5, 3'd3, 3'd7};

  typedef struct {
    bit         color;
    logic [7:0] attr;
    logic [7:0] shown;
    bit         known;
    string      seq;
  } sgr_case_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic cfg_wdata = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  out_t      sgr_expected[$];
  out_t      next_seq[$];
  sgr_case_t dir_cases[$];
  bit        color_on = 1'b1;
  bit        calm = 1'b0;
  int        mismatch_cnt = 0;
  int        item_cnt = 0;
  int        byte_cnt = 0;
  int        seq_cnt = 0;
  int        cfg_cnt = 0;
  int        ready_hold = 0;

  text_attribute_to_ansi_sgr dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #10_000_000;
    $display("Verification failed");
    $finish;
  end

  function automatic logic [7:0] reduce_mono(input logic [7:0] a);
    logic [7:0] w;
    w = a;
    if ((w & ATTR_FG_MASK) != 0) w = w | ATTR_FG_MASK;
    if ((w & ATTR_BG_MASK) != 0) w = w | ATTR_BG_MASK;
    if ((w & ATTR_FG_MASK) != 0 && (w & ATTR_BG_MASK) != 0) w = w & ~ATTR_FG_MASK;
    if (w == 8'h00) w = ATTR_DEFAULT;
    return w;
  endfunction

  function automatic void add_byte(input logic [7:0] b);
    out_t o;
    o.out_byte = b;
    o.last = 1'b0;
    next_seq.push_back(o);
  endfunction

  // Fill next_seq with the SGR bytes that move the terminal from shown to attr
  function automatic void build_sgr_seq(input logic [7:0] attr, input logic [7:0] shown,
                                        input bit color);
    logic [7:0] want;
    logic [7:0] cur;
    out_t       o;
    next_seq.delete();
    want = color ? attr : reduce_mono(attr);
    cur = shown;
    if (want == cur) return;
    add_byte(CHAR_ESC);
    add_byte(CHAR_LBRK);
    if ((!want[3] && cur[3]) || (!want[7] && cur[7]) || want == ATTR_DEFAULT) begin
      add_byte(CHAR_ZERO);
      add_byte(CHAR_SEMI);
      cur = ATTR_DEFAULT;
    end
    if (want[7] && !cur[7]) begin
      add_byte(CHAR_FIVE);
      add_byte(CHAR_SEMI);
    end
    if (want[3] && !cur[3]) begin
      add_byte(CHAR_ONE);
      add_byte(CHAR_SEMI);
    end
    if (want[2:0] != cur[2:0]) begin
      add_byte(CHAR_THREE);
      add_byte(CHAR_ZERO + 8'(ANSI_HUE[want[2:0]]));
      add_byte(CHAR_SEMI);
    end
    if (want[6:4] != cur[6:4]) begin
      add_byte(CHAR_FOUR);
      add_byte(CHAR_ZERO + 8'(ANSI_HUE[want[6:4]]));
      add_byte(CHAR_SEMI);
    end
    if (next_seq.size() <= 2) begin
      next_seq.delete();
      return;
    end
    o.out_byte = CHAR_M;
    o.last = 1'b1;
    next_seq[next_seq.size() - 1] = o;
  endfunction

  function automatic void seq_from_text(input string s);
    out_t o;
    next_seq.delete();
    for (int i = 0; i < s.len(); i++) begin
      o.out_byte = s[i];
      o.last = (i == s.len() - 1);
      next_seq.push_back(o);
    end
  endfunction

  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 30);
  endfunction

  // Present one transaction at a falling edge, hold until accepted
  task automatic push_item(input logic [7:0] attr, input logic [7:0] shown);
    in_t item;
    int  gap;
    item.attr = attr;
    item.current_attr = shown;
    in_data <= item;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    item_cnt++;
    @(negedge clk);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic wait_drained();
    while (sgr_expected.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_color(input bit v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    color_on = v;
    cfg_cnt++;
  endtask

  always @(negedge clk) begin
    if (calm) begin
      out_ready <= 1'b1;
    end else if (ready_hold > 0) begin
      out_ready <= 1'b0;
      ready_hold--;
    end else begin : pick_stall
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 15) begin
        out_ready <= 1'b0;
        ready_hold = $urandom_range(0, 2);
      end else if (r < 17) begin
        out_ready <= 1'b0;
        ready_hold = $urandom_range(8, 40);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        foreach (next_seq[i]) sgr_expected.push_back(next_seq[i]);
      end
      if (out_valid && out_ready) begin : check_byte
        out_t exp_b;
        byte_cnt++;
        if (out_data.last) seq_cnt++;
        if (sgr_expected.size() == 0) begin
          $display("%0t: unexpected byte: expected none, actual %02h last %0b",
                   $time, out_data.out_byte, out_data.last);
          mismatch_cnt++;
        end else begin
          exp_b = sgr_expected.pop_front();
          if (out_data.out_byte !== exp_b.out_byte) begin
            $display("%0t: out_byte mismatch: expected %02h, actual %02h",
                     $time, exp_b.out_byte, out_data.out_byte);
            mismatch_cnt++;
          end
          if (out_data.last !== exp_b.last) begin
            $display("%0t: last mismatch: expected %0b, actual %0b",
                     $time, exp_b.last, out_data.last);
            mismatch_cnt++;
          end
        end
      end
    end
  end

  initial begin
    logic [7:0]  a;
    logic [7:0]  s;
    int unsigned r;

    dir_cases.push_back('{1'b1, 8'h07, 8'h07, 1'b1, ""});
    dir_cases.push_back('{1'b1, 8'h07, 8'h00, 1'b1, "\033[0m"});
    dir_cases.push_back('{1'b1, 8'hFF, 8'h00, 1'b1, "\033[5;1;37;47m"});
    dir_cases.push_back('{1'b1, 8'h00, 8'hFF, 1'b1, "\033[0;30m"});
    dir_cases.push_back('{1'b1, 8'h70, 8'h07, 1'b1, "\033[30;47m"});
    dir_cases.push_back('{1'b1, 8'h01, 8'h07, 1'b0, ""});
    dir_cases.push_back('{1'b1, 8'h02, 8'h07, 1'b0, ""});
    dir_cases.push_back('{1'b1, 8'h04, 8'h07, 1'b0, ""});
    dir_cases.push_back('{1'b1, 8'h0F, 8'h07, 1'b0, ""});
    dir_cases.push_back('{1'b1, 8'h87, 8'h07, 1'b0, ""});
    dir_cases.push_back('{1'b1, 8'h8F, 8'h0F, 1'b0, ""});
    dir_cases.push_back('{1'b1, 8'h07, 8'h8F, 1'b0, ""});
    dir_cases.push_back('{1'b1, 8'h17, 8'h07, 1'b0, ""});
    dir_cases.push_back('{1'b1, 8'h47, 8'h07, 1'b0, ""});
    dir_cases.push_back('{1'b1, 8'h0F, 8'h8F, 1'b0, ""});
    dir_cases.push_back('{1'b1, 8'hF0, 8'h0F, 1'b0, ""});
    dir_cases.push_back('{1'b1, 8'h7F, 8'hF7, 1'b0, ""});
    dir_cases.push_back('{1'b0, 8'h00, 8'h07, 1'b1, ""});
    dir_cases.push_back('{1'b0, 8'h00, 8'h00, 1'b1, "\033[0m"});
    dir_cases.push_back('{1'b0, 8'h11, 8'h07, 1'b1, "\033[30;47m"});
    dir_cases.push_back('{1'b0, 8'h88, 8'h07, 1'b1, "\033[5;1;30m"});
    dir_cases.push_back('{1'b0, 8'h0A, 8'h07, 1'b0, ""});
    dir_cases.push_back('{1'b0, 8'hFF, 8'h70, 1'b0, ""});
    dir_cases.push_back('{1'b0, 8'h80, 8'h07, 1'b0, ""});
    dir_cases.push_back('{1'b1, 8'h3C, 8'h07, 1'b0, ""});

    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_cases[i]) begin
      if (dir_cases[i].color != color_on) begin
        in_valid <= 1'b0;
        wait_drained();
        set_color(dir_cases[i].color);
      end
      if (dir_cases[i].known) seq_from_text(dir_cases[i].seq);
      else build_sgr_seq(dir_cases[i].attr, dir_cases[i].shown, color_on);
      push_item(dir_cases[i].attr, dir_cases[i].shown);
    end

    for (int p = 0; p < PHASES; p++) begin
      in_valid <= 1'b0;
      wait_drained();
      calm = (p == 3);
      set_color(1'(p % 2));
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        r = $urandom_range(0, 99);
        a = 8'($urandom);
        if (r < 55) s = 8'($urandom);
        else if (r < 85) s = a ^ (8'd1 << $urandom_range(0, 7)) ^ (8'd1 << $urandom_range(0, 7));
        else if (r < 92) s = color_on ? a : reduce_mono(a);
        else s = ATTR_DEFAULT;
        build_sgr_seq(a, s, color_on);
        push_item(a, s);
      end
    end

    in_valid <= 1'b0;
    calm = 1'b0;
    wait_drained();
    $display("Covered %0d attribute transactions (%0d directed), %0d config writes,",
             item_cnt, dir_cases.size(), cfg_cnt);
    $display("in color and monochrome modes; checked %0d SGR bytes in %0d sequences.",
             byte_cnt, seq_cnt);
    if (mismatch_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
